[sv/pcg_pkg.sv]
package pcg_pkg;

	localparam int unsigned STATE_W = 64;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned STREAM_W = 63;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [STATE_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
	localparam logic [STATE_W-1:0] LCG_STATE_RESET = 64'd0;
	localparam logic [STATE_W-1:0] LCG_INCREMENT_RESET = 64'd1;

	localparam int unsigned XSH_SHIFT = 18;
	localparam int unsigned XSH_DROP = 27;
	localparam int unsigned ROT_LSB = 59;

	localparam logic [CFG_INDEX_W-1:0] CFG_SEED_VALUE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_SELECT = 1'b1;

	typedef enum logic [1:0] {
		OP_SEED = 2'd0,
		OP_RESTORE = 2'd1,
		OP_RAW = 2'd2,
		OP_BOUNDED = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_EVEN_INCREMENT = 2'd1,
		STATUS_ZERO_BOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_LL,
		S_MUL_HL,
		S_MUL_LH,
		S_ACC,
		S_ADD,
		S_SEED_ADD,
		S_THRESH,
		S_CHECK,
		S_REDUCE,
		S_DONE
	} seq_state_t;

endpackage

[sv/pcg32_random_generator.sv]
// Restore and zero-bound requests go from acceptance straight to the done state. A raw draw
// runs one LCG step; a seed request runs two with the seed add between. A bounded draw computes
// the threshold, then steps until a candidate is not below it, then the final remainder.
// The block takes one request at a time; the 32x32 multiplier serves every LCG step and the
// one-bit-per-cycle divider both remainders. Reset loads state 0 and increment 1.
module pcg32_random_generator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write_en,
	input  logic [pcg_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [pcg_pkg::STATE_W-1:0]             cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  pcg_pkg::opcode_t                        opcode,
	input  logic [pcg_pkg::STATE_W-1:0]             restore_state,
	input  logic [pcg_pkg::STATE_W-1:0]             restore_increment,
	input  logic [pcg_pkg::WORD_W-1:0]              upper_bound,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [pcg_pkg::WORD_W-1:0]              random_value,
	output pcg_pkg::status_t                        status
);
	import pcg_pkg::*;

	seq_state_t state_q, state_d;

	logic [STATE_W-1:0]  seed_value_q;
	logic [STREAM_W-1:0] stream_select_q;
	logic [STATE_W-1:0]  lcg_state_q;
	logic [STATE_W-1:0]  lcg_increment_q;

	opcode_t             op_q;
	logic                seed_second_q;
	logic [WORD_W-1:0]   bound_q;
	logic [WORD_W-1:0]   thresh_q;
	logic [WORD_W-1:0]   cand_q;
	logic [WORD_W-1:0]   value_q;
	status_t             status_q;

	logic [STATE_W-1:0]  prod_q;
	logic [STATE_W-1:0]  acc_q;

	logic [WORD_W-1:0]   div_rem_q;
	logic [WORD_W-1:0]   div_quo_q;
	logic [4:0]          div_cnt_q;

	logic                out_valid_q;
	logic [WORD_W-1:0]   random_value_q;
	status_t             status_out_q;

	logic                accept;
	logic                out_free;
	logic [WORD_W-1:0]   mul_a;
	logic [WORD_W-1:0]   mul_b;
	logic [STATE_W-1:0]  mul_p;
	logic [STATE_W-1:0]  xsh;
	logic [WORD_W-1:0]   xs;
	logic [4:0]          rot;
	logic [2*WORD_W-1:0] rot_pair;
	logic [WORD_W-1:0]   perm;
	logic [WORD_W:0]     div_shift;
	logic [WORD_W+1:0]   div_diff;
	logic [WORD_W-1:0]   div_rem_next;
	logic                div_last;

	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// XSH-RR permutation of the state before the step.
	assign xsh = (lcg_state_q ^ (lcg_state_q >> XSH_SHIFT)) >> XSH_DROP;
	assign xs = xsh[WORD_W-1:0];
	assign rot = lcg_state_q[STATE_W-1:ROT_LSB];
	assign rot_pair = {xs, xs} >> rot;
	assign perm = rot_pair[WORD_W-1:0];

	always_comb begin
		unique case (state_q)
			S_MUL_HL: begin
				mul_a = lcg_state_q[STATE_W-1:WORD_W];
				mul_b = LCG_MULT[WORD_W-1:0];
			end
			S_MUL_LH: begin
				mul_a = lcg_state_q[WORD_W-1:0];
				mul_b = LCG_MULT[STATE_W-1:WORD_W];
			end
			default: begin
				mul_a = lcg_state_q[WORD_W-1:0];
				mul_b = LCG_MULT[WORD_W-1:0];
			end
		endcase
	end

	assign mul_p = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};

	// Restoring remainder step, one dividend bit per cycle.
	assign div_shift = {div_rem_q, div_quo_q[WORD_W-1]};
	assign div_diff = {1'b0, div_shift} - {2'b00, bound_q};
	assign div_rem_next = div_diff[WORD_W+1] ? div_shift[WORD_W-1:0] : div_diff[WORD_W-1:0];
	assign div_last = (div_cnt_q == 5'd31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_SEED:    state_d = S_MUL_LL;
						OP_RESTORE: state_d = S_DONE;
						OP_RAW:     state_d = S_MUL_LL;
						OP_BOUNDED: state_d = (upper_bound == '0) ? S_DONE : S_THRESH;
					endcase
				end
			end
			S_MUL_LL: state_d = S_MUL_HL;
			S_MUL_HL: state_d = S_MUL_LH;
			S_MUL_LH: state_d = S_ACC;
			S_ACC:    state_d = S_ADD;
			S_ADD: begin
				unique case (op_q)
					OP_SEED:    state_d = seed_second_q ? S_DONE : S_SEED_ADD;
					OP_BOUNDED: state_d = S_CHECK;
					default:    state_d = S_DONE;
				endcase
			end
			S_SEED_ADD: state_d = S_MUL_LL;
			S_THRESH: begin
				if (div_last) begin
					state_d = S_MUL_LL;
				end
			end
			S_CHECK:  state_d = (cand_q >= thresh_q) ? S_REDUCE : S_MUL_LL;
			S_REDUCE: begin
				if (div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_value_q <= '0;
			stream_select_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_SEED_VALUE:    seed_value_q <= cfg_data;
				CFG_STREAM_SELECT: stream_select_q <= cfg_data[STREAM_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_state_q <= LCG_STATE_RESET;
			lcg_increment_q <= LCG_INCREMENT_RESET;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_SEED) begin
						lcg_state_q <= '0;
						lcg_increment_q <= {stream_select_q, 1'b1};
					end else if (accept && opcode == OP_RESTORE && restore_increment[0]) begin
						lcg_state_q <= restore_state;
						lcg_increment_q <= restore_increment;
					end
				end
				S_ADD:      lcg_state_q <= acc_q + lcg_increment_q;
				S_SEED_ADD: lcg_state_q <= lcg_state_q + seed_value_q;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= opcode;
					bound_q <= upper_bound;
					seed_second_q <= 1'b0;
					value_q <= '0;
					status_q <= STATUS_OK;
					div_rem_q <= '0;
					div_quo_q <= '0 - upper_bound;
					div_cnt_q <= '0;
					if (opcode == OP_RESTORE && !restore_increment[0]) begin
						status_q <= STATUS_EVEN_INCREMENT;
					end else if (opcode == OP_BOUNDED && upper_bound == '0) begin
						status_q <= STATUS_ZERO_BOUND;
					end
				end
			end
			S_MUL_LL: begin
				prod_q <= mul_p;
				cand_q <= perm;
			end
			S_MUL_HL: begin
				acc_q <= prod_q;
				prod_q <= mul_p;
			end
			S_MUL_LH: begin
				acc_q[STATE_W-1:WORD_W] <= acc_q[STATE_W-1:WORD_W] + prod_q[WORD_W-1:0];
				prod_q <= mul_p;
			end
			S_ACC: begin
				acc_q[STATE_W-1:WORD_W] <= acc_q[STATE_W-1:WORD_W] + prod_q[WORD_W-1:0];
			end
			S_ADD: begin
				if (op_q == OP_RAW) begin
					value_q <= cand_q;
				end
			end
			S_SEED_ADD: begin
				seed_second_q <= 1'b1;
			end
			S_THRESH: begin
				div_rem_q <= div_rem_next;
				div_quo_q <= div_quo_q << 1;
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_last) begin
					thresh_q <= div_rem_next;
				end
			end
			S_CHECK: begin
				div_rem_q <= '0;
				div_quo_q <= cand_q;
				div_cnt_q <= '0;
			end
			S_REDUCE: begin
				div_rem_q <= div_rem_next;
				div_quo_q <= div_quo_q << 1;
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_last) begin
					value_q <= div_rem_next;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			random_value_q <= value_q;
			status_out_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign random_value = random_value_q;
	assign status = status_out_q;

`ifndef NO_ASSERTIONS
	a_increment_odd: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_increment_q[0])
		else $error("Generator increment became even.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("Accepted request did not start the sequencer.");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_out_q != STATUS_OK |-> random_value_q == '0)
		else $error("Rejected request returned a nonzero value.");

	a_remainder_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_THRESH || state_q == S_REDUCE |-> div_rem_q < bound_q)
		else $error("Divider remainder reached the bound.");

	a_done_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("Finished request was not presented.");
`endif

endmodule

[test/tb_pcg32_random_generator.sv]
`timescale 1ns / 100ps

module tb_pcg32_random_generator;
	import pcg_pkg::*;

	typedef struct {
		bit [WORD_W-1:0] value;
		status_t         code;
	} draw_result_t;

	class rng_scoreboard;
		bit [STATE_W-1:0]  lcg_state;
		bit [STATE_W-1:0]  lcg_incr;
		bit [STATE_W-1:0]  seed_reg;
		bit [STREAM_W-1:0] stream_reg;
		draw_result_t      expected_q[$];
		int                failures;

		function new();
			lcg_state = LCG_STATE_RESET;
			lcg_incr = LCG_INCREMENT_RESET;
			seed_reg = '0;
			stream_reg = '0;
			failures = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, bit [STATE_W-1:0] data);
			if (idx == CFG_SEED_VALUE) begin
				seed_reg = data;
			end else begin
				stream_reg = data[STREAM_W-1:0];
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Steps the LCG and returns the XSH-RR output of the state before the step.
		function bit [WORD_W-1:0] advance();
			bit [STATE_W-1:0] prior;
			bit [STATE_W-1:0] folded;
			bit [WORD_W-1:0]  xs;
			int unsigned      rot;
			prior = lcg_state;
			lcg_state = prior * LCG_MULT + lcg_incr;
			folded = ((prior >> XSH_SHIFT) ^ prior) >> XSH_DROP;
			xs = folded[WORD_W-1:0];
			rot = prior[STATE_W-1:ROT_LSB];
			return (xs >> rot) | (xs << ((32 - rot) & 31));
		endfunction

		function void note_request(opcode_t op, bit [STATE_W-1:0] rs, bit [STATE_W-1:0] ri,
				bit [WORD_W-1:0] ub);
			draw_result_t    res;
			bit [WORD_W-1:0] neg;
			bit [WORD_W-1:0] thresh;
			bit [WORD_W-1:0] cand;
			bit [WORD_W-1:0] unused;
			res.value = '0;
			res.code = STATUS_OK;
			case (op)
				OP_SEED: begin
					lcg_state = '0;
					lcg_incr = {stream_reg, 1'b1};
					unused = advance();
					lcg_state = lcg_state + seed_reg;
					unused = advance();
				end
				OP_RESTORE: begin
					if (ri[0] == 1'b0) begin
						res.code = STATUS_EVEN_INCREMENT;
					end else begin
						lcg_state = rs;
						lcg_incr = ri;
					end
				end
				OP_RAW: begin
					res.value = advance();
				end
				default: begin
					if (ub == '0) begin
						res.code = STATUS_ZERO_BOUND;
					end else begin
						neg = '0 - ub;
						thresh = neg % ub;
						do begin
							cand = advance();
						end while (cand < thresh);
						res.value = cand % ub;
					end
				end
			endcase
			expected_q.insert(expected_q.size(), res);
		endfunction

		function void check_result(bit [WORD_W-1:0] value, status_t code);
			draw_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("Result with no request pending: random_value %h, status %0d",
					value, code);
				failures++;
			end else begin
				exp_res = expected_q.pop_front();
				if (value !== exp_res.value) begin
					$error("random_value: expected %h, actual %h", exp_res.value, value);
					failures++;
				end
				if (code !== exp_res.code) begin
					$error("status: expected %0d, actual %0d", exp_res.code, code);
					failures++;
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_SEED_VALUE;
	logic [STATE_W-1:0]     cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	opcode_t                opcode = OP_RAW;
	logic [STATE_W-1:0]     restore_state = '0;
	logic [STATE_W-1:0]     restore_increment = '0;
	logic [WORD_W-1:0]      upper_bound = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [WORD_W-1:0]      random_value;
	status_t                status;

	rng_scoreboard sb = new();
	bit            idle_on = 1'b0;

	pcg32_random_generator DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.restore_state     (restore_state),
		.restore_increment (restore_increment),
		.upper_bound       (upper_bound),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.random_value      (random_value),
		.status            (status)
	);

	always #6 clk = ~clk;

	function int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function bit [STATE_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic wait_drained();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, bit [STATE_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic send_request(opcode_t op, bit [STATE_W-1:0] rs, bit [STATE_W-1:0] ri,
			bit [WORD_W-1:0] ub);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		restore_state <= rs;
		restore_increment <= ri;
		upper_bound <= ub;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.note_request(op, rs, ri, ub);
	endtask

	task automatic send_random_request();
		int              r;
		opcode_t         op;
		bit [STATE_W-1:0] rs;
		bit [STATE_W-1:0] ri;
		bit [WORD_W-1:0]  ub;
		rs = rand64();
		ri = rand64();
		ub = $urandom;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			op = OP_SEED;
		end else if (r < 28) begin
			op = OP_RESTORE;
			if ($urandom_range(0, 99) < 85) begin
				ri[0] = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				rs = $urandom_range(0, 1) ? '0 : '1;
			end
		end else if (r < 62) begin
			op = OP_RAW;
		end else begin
			op = OP_BOUNDED;
			r = $urandom_range(0, 99);
			if (r < 5) begin
				ub = '0;
			end else if (r < 65) begin
				ub = $urandom_range(1, 64);
			end else if (r < 80) begin
				ub = $urandom_range(1, 65535);
			end
		end
		send_request(op, rs, ri, ub);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				sb.check_result(random_value, status);
			end
		end
	end

	initial begin
		int stall_left;
		int gap;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					stall_left = gap - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		bit [STATE_W-1:0] seeds[4];
		bit [STATE_W-1:0] streams[4];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests, starting from the reset state of the generator.
		send_request(OP_RAW, '0, '0, '0);
		send_request(OP_BOUNDED, '0, '0, 32'd1);
		send_request(OP_BOUNDED, '1, '1, '0);
		send_request(OP_RESTORE, '1, '0, '0);
		send_request(OP_RESTORE, '1, '1, '1);
		send_request(OP_RAW, '0, '0, '0);
		send_request(OP_BOUNDED, '0, '0, 32'hFFFF_FFFF);
		send_request(OP_RESTORE, '0, 64'd1, '0);
		send_request(OP_RAW, '1, '1, '1);
		send_request(OP_BOUNDED, '0, '0, 32'h8000_0001);
		send_request(OP_BOUNDED, '0, '0, 32'h8000_0000);
		send_request(OP_RESTORE, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		send_request(OP_BOUNDED, '0, '0, 32'd3);
		send_request(OP_SEED, '1, '1, '1);
		send_request(OP_RAW, '0, '0, '0);
		send_request(OP_RESTORE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '0);
		send_request(OP_BOUNDED, '0, '0, 32'd7);
		send_request(OP_RESTORE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		send_request(OP_RAW, '0, '0, '0);
		send_request(OP_BOUNDED, '0, '0, 32'd2);

		seeds[0] = '0;
		streams[0] = '0;
		seeds[1] = '1;
		streams[1] = '1;
		seeds[2] = rand64();
		streams[2] = rand64();
		seeds[3] = rand64();
		streams[3] = '0;
		for (int phase = 0; phase < 4; phase++) begin
			in_valid <= 1'b0;
			wait_drained();
			repeat (2) @(posedge clk);
			write_register(CFG_SEED_VALUE, seeds[phase]);
			write_register(CFG_STREAM_SELECT, streams[phase]);
			cfg_write_en <= 1'b0;
			idle_on = 1'b0;
			send_request(OP_SEED, rand64(), rand64(), $urandom);
			for (int n = 0; n < 420; n++) begin
				if (n == 100) begin
					idle_on = 1'b1;
				end
				if ($urandom_range(0, 149) == 0) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				send_random_request();
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/pcg_pkg.sv
sv/pcg32_random_generator.sv
test/tb_pcg32_random_generator.sv
